// ===== design/assert_macros.svh =====
// Assertion macros used by the converter's serializer module.
// No dependencies; the SYNTH define selects empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SBDA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define SBDA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define SBDA_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define SBDA_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== design/sbda_pkg.sv =====
// Types and constants of the signed binary to decimal ASCII converter.
// No dependencies.
package sbda_pkg;

    localparam int MAG_W          = 32;
    localparam int NDIG           = 10;
    localparam int BCD_W          = NDIG * 4;
    localparam int BITS_PER_STAGE = 4;
    localparam int NSTAGE         = MAG_W / BITS_PER_STAGE;
    localparam int POS_W          = 4;
    localparam int CHAR_W         = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [MAG_W-1:0] mag;
        logic             neg;
    } t_dd;

endpackage

// ===== design/sbda_dabble_stage.sv =====
// One pipeline stage of the double-dabble conversion: four magnitude bits.
// Depends on sbda_pkg.
module sbda_dabble_stage
    import sbda_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_dd  i_data,
    output logic o_ready,
    output logic o_valid,
    output t_dd  o_data,
    input  logic i_ready
);

    logic r_vld;
    t_dd  r_data;
    t_dd  n_data;

    logic [BCD_W-1:0] w_bcd;
    logic [MAG_W-1:0] w_mag;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    always_comb begin
        w_bcd = i_data.bcd;
        w_mag = i_data.mag;
        for (int s = 0; s < BITS_PER_STAGE; s++) begin
            for (int j = 0; j < NDIG; j++) begin
                if (w_bcd[j*4 +: 4] >= 4'd5) begin
                    w_bcd[j*4 +: 4] = w_bcd[j*4 +: 4] + 4'd3;
                end
            end
            w_bcd = {w_bcd[BCD_W-2:0], w_mag[MAG_W-1]};
            w_mag = {w_mag[MAG_W-2:0], 1'b0};
        end
        n_data.bcd = w_bcd;
        n_data.mag = w_mag;
        n_data.neg = i_data.neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== design/sbda_serializer.sv =====
// Character serializer: holds one converted number and emits its text.
// Depends on sbda_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sbda_serializer
    import sbda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_dd               i_data,
    output logic              o_ready,
    output logic              o_valid,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_last,
    input  logic              i_ready
);

    logic             r_busy;
    logic             r_sign;
    logic [POS_W-1:0] r_pos;
    logic [BCD_W-1:0] r_bcd;

    logic [POS_W-1:0] w_msd;
    logic [3:0]       w_digit;
    logic             w_fire;
    logic             w_load;

    always_comb begin
        w_msd = '0;
        for (int j = 0; j < NDIG; j++) begin
            if (i_data.bcd[j*4 +: 4] != 4'd0) begin
                w_msd = POS_W'(j);
            end
        end
    end

    assign w_digit = r_bcd[{r_pos, 2'b00} +: 4];
    assign o_valid = r_busy;
    assign o_char  = r_sign ? ASCII_MINUS : (ASCII_ZERO + {4'd0, w_digit});
    assign o_last  = !r_sign && (r_pos == '0);
    assign w_fire  = r_busy && i_ready;
    assign o_ready = !r_busy || (w_fire && o_last);
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sign <= 1'b0;
            r_pos  <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_sign <= i_data.neg;
            r_pos  <= w_msd;
        end else if (w_fire) begin
            if (r_sign) begin
                r_sign <= 1'b0;
            end else if (r_pos == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_pos <= r_pos - POS_W'(1);
            end
        end
        if (w_load) begin
            r_bcd <= i_data.bcd;
        end
    end

    `SBDA_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, r_busy, r_pos < POS_W'(NDIG))
    `SBDA_ASSERT_NXT(a_sign_first, i_clk, i_rst_n, w_load && i_data.neg, o_char == ASCII_MINUS && !o_last)
    `SBDA_ASSERT_NXT(a_idle_after_last, i_clk, i_rst_n, w_fire && o_last && !i_valid, !o_valid)

endmodule

// ===== design/signed_binary_to_decimal_ascii_core.sv =====
// Signed 32-bit binary to decimal ASCII converter, top level.
// Depends on sbda_pkg, sbda_dabble_stage and sbda_serializer.
//
// Usage:
//   Slave channel s_axis carries one signed 32-bit integer per item in
//   s_axis_tdata. Master channel m_axis carries one ASCII character per
//   item: '-' first for a negative value, then the decimal digits, most
//   significant first, with no leading zeros. m_axis_tlast marks the final
//   character of each number. Zero gives the single character '0'.
//   The first character of a number shows on m_axis after its item passes
//   from the input register through the eight double-dabble stages of four
//   bits each, then the serializer load.
//   Each number has 1 to 11 characters; the serializer emits one character
//   per cycle while m_axis_tready is high. The next number is loaded in the
//   cycle its predecessor's last character is taken, so the stream has no
//   gaps when the next number is already waiting in the last stage.
//   Reset clears all valid bits; no item is in flight afterwards.
//   When m_axis_tready is low, the current character holds and the
//   pipeline stages fill up before s_axis_tready drops; nothing is lost.
module signed_binary_to_decimal_ascii_core
    import sbda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] character
    output logic        m_axis_tlast
);

    logic r_in_vld;
    t_dd  r_in_data;

    logic w_vld [NSTAGE+1];
    logic w_rdy [NSTAGE+1];
    t_dd  w_dat [NSTAGE+1];

    assign s_axis_tready = !r_in_vld || w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (s_axis_tready) begin
            r_in_data.neg <= s_axis_tdata[MAG_W-1];
            r_in_data.mag <= s_axis_tdata[MAG_W-1] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
            r_in_data.bcd <= '0;
        end
    end

    assign w_vld[0] = r_in_vld;
    assign w_dat[0] = r_in_data;

    for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
        sbda_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .i_data  (w_dat[g]),
            .o_ready (w_rdy[g]),
            .o_valid (w_vld[g+1]),
            .o_data  (w_dat[g+1]),
            .i_ready (w_rdy[g+1])
        );
    end

    sbda_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_vld[NSTAGE]),
        .i_data  (w_dat[NSTAGE]),
        .o_ready (w_rdy[NSTAGE]),
        .o_valid (m_axis_tvalid),
        .o_char  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .i_ready (m_axis_tready)
    );

endmodule

// ===== dv/tb_top.sv =====
// Testbench for signed_binary_to_decimal_ascii_core: sends signed 32-bit values and checks
// every output character and tlast against expected strings or a built-in converter model.
// Depends on sbda_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_top;
    import sbda_pkg::*;

    localparam int NDIR       = 16;
    localparam int NRAND      = 66;
    localparam int TAIL_WAIT  = 30;
    localparam int IDLE_LIMIT = 1000;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    t_char_item  pending_chars[$];
    int          err_count   = 0;
    int          values_sent = 0;
    int          neg_sent    = 0;
    int          chars_seen  = 0;
    int          idle_cycles = 0;
    int          src_idle_pct  = 0;
    int          sink_stall_pct = 0;

    logic [31:0] dir_value [NDIR] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
        32'd999999999, -32'sd999999999, 32'h5555_5555, 32'hAAAA_AAAA,
        32'd123456789, -32'sd100
    };
    string dir_text [NDIR] = '{
        "0", "1", "-1", "9", "10", "-10",
        "2147483647", "-2147483648", "-2147483647", "1000000000",
        "999999999", "", "", "", "", ""
    };

    signed_binary_to_decimal_ascii_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] value
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] character
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic void expect_decimal(input logic [31:0] v);
        logic [31:0] mag;
        logic [3:0]  digs [NDIG];
        int          nd;
        mag = v[31] ? (~v + 32'd1) : v;
        nd  = 0;
        do begin
            digs[nd] = 4'(mag % 10);
            mag      = mag / 10;
            nd++;
        end while (mag != 0 && nd < NDIG);
        if (v[31]) begin
            pending_chars.push_back('{ASCII_MINUS, 1'b0});
        end
        for (int d = nd - 1; d >= 0; d--) begin
            pending_chars.push_back('{8'(ASCII_ZERO + digs[d]), d == 0});
        end
    endfunction

    function automatic void expect_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            pending_chars.push_back('{8'(text[i]), i == text.len() - 1});
        end
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] p;
        logic [31:0] v;
        p = 32'd1;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 99);
            1: begin
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = p + $urandom_range(0, 2) - 32'd1;
            end
            2: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                        : 32'h8000_0000 + $urandom_range(0, 3);
            3: v = $urandom_range(0, 99999);
            default: v = $urandom;
        endcase
        if (v != 32'h8000_0000 && $urandom_range(0, 1)) begin
            v = -v;
        end
        return v;
    endfunction

    task automatic send_value(input logic [31:0] v, input string text);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = v;
        do @(posedge i_clk); while (!s_axis_tready);
        if (text.len() != 0) begin
            expect_text(text);
        end else begin
            expect_decimal(v);
        end
        values_sent++;
        if (v[31]) begin
            neg_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic drain_output();
        s_axis_tvalid = 1'b0;
        while (pending_chars.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            chars_seen++;
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char %0d", m_axis_tdata));
            end else begin
                if (m_axis_tdata !== pending_chars[0].ch) begin
                    report_mismatch($sformatf("char got %0d exp %0d",
                                              m_axis_tdata, pending_chars[0].ch));
                end
                if (m_axis_tlast !== pending_chars[0].last) begin
                    report_mismatch($sformatf("tlast got %0b exp %0b on char %0d",
                                              m_axis_tlast, pending_chars[0].last,
                                              pending_chars[0].ch));
                end
                void'(pending_chars.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TIMEOUT after %0d idle cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'd0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < NDIR; i++) begin
            send_value(dir_value[i], dir_text[i]);
        end
        drain_output();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
                default: begin src_idle_pct = 17; sink_stall_pct = 17; end
            endcase
            for (int n = 0; n < NRAND; n++) begin
                send_value(pick_value(), "");
                if (ph == 2 && n == NRAND / 2) begin
                    drain_output();
                end
            end
            drain_output();
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            report_mismatch($sformatf("%0d chars never arrived", pending_chars.size()));
        end
        $display("Converted %0d values (%0d negative), %0d chars checked, four idle/stall mixes",
                 values_sent, neg_sent, chars_seen);
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
